>>> hw/rtl/owtrm_pkg.sv
// Shared types and constants of the one-wire temperature read master.
// No dependencies; every other file of the block imports this package.
package owtrm_pkg;

   // Widths of the tick counter and of the configuration port.
   localparam int TICK_W     = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // Command bytes sent on the bus.
   localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
   localparam logic [7:0] CMD_CONVERT   = 8'h44;
   localparam logic [7:0] CMD_READ_SCR  = 8'hBE;

   // Byte steps of the sequence.
   localparam logic [2:0] STEP_CONVERT  = 3'd1;
   localparam logic [2:0] STEP_READ_SCR = 3'd3;
   localparam logic [2:0] STEP_WAIT     = 3'd2;
   localparam logic [2:0] STEP_RD_LOW   = 3'd4;
   localparam logic [2:0] STEP_RD_HIGH  = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_RESET_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRES_TMO    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RECOVERY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WRITE_SLOT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RD_SAMPLE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RD_RECOVER  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CONV_WAIT   = 3'd6;

   // Sequencer phases.
   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_RST_LOW  = 3'd1,
      PH_PRESENCE = 3'd2,
      PH_RECOVER  = 3'd3,
      PH_WRITE    = 3'd4,
      PH_CONVERT  = 3'd5,
      PH_READ     = 3'd6
   } phase_type;

   // Timing configuration as seen by the sequencer.
   typedef struct packed {
      logic [11:0] reset_low_ticks;
      logic [15:0] presence_timeout_ticks;
      logic [15:0] recovery_ticks;
      logic [7:0]  write_slot_ticks;
      logic [5:0]  read_sample_ticks;
      logic [7:0]  read_recover_ticks;
      logic [19:0] convert_wait_ticks;
   } cfg_type;

   // One response of the sequencer.
   typedef struct packed {
      logic        drive_low;
      logic        busy_res;
      logic        done_res;
      logic        presence_missing;
      logic [15:0] temperature_raw;
   } rsp_payload_type;

endpackage

>>> hw/rtl/owtrm_if.sv
// Valid/ready channel interfaces of the one-wire temperature read master.
// Depends on owtrm_pkg for the configuration port widths.

// Tick request channel.
interface owtrm_req_if;
   logic valid;
   logic ready;
   logic start_req;
   logic line_level;

   modport source (output valid, output start_req, output line_level, input ready);
   modport sink   (input valid, input start_req, input line_level, output ready);
endinterface

// Response channel, one response for every request.
interface owtrm_rsp_if;
   logic        valid;
   logic        ready;
   logic        drive_low;
   logic        busy_res;
   logic        done_res;
   logic        presence_missing;
   logic [15:0] temperature_raw;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output presence_missing, output temperature_raw, input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input presence_missing, input temperature_raw, output ready);
endinterface

// Configuration write channel.
interface owtrm_csr_if import owtrm_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/onewire_temperature_read_master.sv
// Top level of the one-wire temperature read master: request register,
// sequencer, response register. Depends on owtrm_pkg, owtrm_if, owtrm_csr, owtrm_seq.
//
//  channel   direction  handshake      payload
//  req_bus   in         valid/ready    start_req, line_level (one bus tick)
//  rsp_bus   out        valid/ready    drive_low, busy_res, done_res,
//                                      presence_missing, temperature_raw
//  csr_bus   in         valid/ready    index (3), data (20)
//
// One request per clock sustained while rsp_bus takes every response; each request is one
// bus tick and gives one response, carried through the request register and then the
// single-pass sequencer step into the response register.
// Reset is synchronous and active high; it loads the register defaults and
// sets the sequencer idle. There is no clearing pass.
// A stalled response holds in its register; the request register still fills,
// and req_bus.ready falls only when both are full.
module onewire_temperature_read_master import owtrm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   owtrm_req_if.sink   req_bus,
   owtrm_rsp_if.source rsp_bus,
   owtrm_csr_if.sink   csr_bus
);

   logic            req_valid_ff, req_valid_in;
   logic            req_start_ff, req_start_in;
   logic            req_line_ff,  req_line_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff,  rsp_data_in;
   logic            step_fire;
   cfg_type         cfg;
   rsp_payload_type seq_res;

   owtrm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   owtrm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_fire),
      .start_req  (req_start_ff),
      .line_level (req_line_ff),
      .cfg        (cfg),
      .res        (seq_res)
   );

   // A held request steps the sequencer when the response slot is free or being emptied.
   assign step_fire     = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || step_fire;

   // Request register.
   always_comb begin
      req_valid_in = req_valid_ff;
      req_start_in = req_start_ff;
      req_line_in  = req_line_ff;
      if (step_fire) begin
         req_valid_in = 1'b0;
      end
      if (req_bus.valid && req_bus.ready) begin
         req_valid_in = 1'b1;
         req_start_in = req_bus.start_req;
         req_line_in  = req_bus.line_level;
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (step_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_start_ff <= req_start_in;
      req_line_ff  <= req_line_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.drive_low        = rsp_data_ff.drive_low;
   assign rsp_bus.busy_res         = rsp_data_ff.busy_res;
   assign rsp_bus.done_res         = rsp_data_ff.done_res;
   assign rsp_bus.presence_missing = rsp_data_ff.presence_missing;
   assign rsp_bus.temperature_raw  = rsp_data_ff.temperature_raw;

endmodule

>>> hw/rtl/owtrm_csr.sv
// Configuration registers of the one-wire temperature read master.
// Depends on owtrm_pkg and on owtrm_csr_if.
module owtrm_csr import owtrm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   owtrm_csr_if.sink      csr_bus,
   output cfg_type        cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken at once.
   assign csr_bus.ready = 1'b1;

   // Decode a write; values are cut to the register width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_RESET_LOW:  cfg_in.reset_low_ticks        = csr_bus.data[11:0];
            REG_PRES_TMO:   cfg_in.presence_timeout_ticks = csr_bus.data[15:0];
            REG_RECOVERY:   cfg_in.recovery_ticks         = csr_bus.data[15:0];
            REG_WRITE_SLOT: cfg_in.write_slot_ticks       = csr_bus.data[7:0];
            REG_RD_SAMPLE:  cfg_in.read_sample_ticks      = csr_bus.data[5:0];
            REG_RD_RECOVER: cfg_in.read_recover_ticks     = csr_bus.data[7:0];
            REG_CONV_WAIT:  cfg_in.convert_wait_ticks     = csr_bus.data[19:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks        <= 12'd642;
         cfg_ff.presence_timeout_ticks <= 16'd5000;
         cfg_ff.recovery_ticks         <= 16'd1000;
         cfg_ff.write_slot_ticks       <= 8'd68;
         cfg_ff.read_sample_ticks      <= 6'd6;
         cfg_ff.read_recover_ticks     <= 8'd48;
         cfg_ff.convert_wait_ticks     <= 20'd100000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/owtrm_seq.sv
// Bus sequencer of the one-wire temperature read master: phase, counters,
// shift byte and result word, advanced by one tick per step. Depends on owtrm_pkg.
module owtrm_seq import owtrm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  logic            start_req,
   input  logic            line_level,
   input  cfg_type         cfg,
   output rsp_payload_type res
);

   phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [2:0]        bit_ff, bit_in;
   logic [2:0]        step_ff, step_in;
   logic [7:0]        shift_ff, shift_in;
   logic [15:0]       result_ff, result_in;
   logic              flag_ff, flag_in;

   logic [TICK_W:0]   tick_plus;
   logic [2:0]        step_plus;
   logic [5:0]        sample_eff;
   logic [8:0]        rd_end_lim;
   logic              rd_sample_hit;
   logic              rd_end;
   logic [7:0]        rd_shift;
   logic              drive;
   logic              done;

   // Command byte sent at a given byte step.
   function automatic logic [7:0] command_for(input logic [2:0] stepno);
      logic [7:0] cmd;
      cmd = CMD_SKIP_ROM;
      if (stepno == STEP_CONVERT) cmd = CMD_CONVERT;
      if (stepno == STEP_READ_SCR) cmd = CMD_READ_SCR;
      return cmd;
   endfunction

   // Shared counter arithmetic.
   assign tick_plus     = {1'b0, tick_ff} + {{TICK_W{1'b0}}, 1'b1};
   assign step_plus     = step_ff + 3'd1;
   assign sample_eff    = (cfg.read_sample_ticks == 6'd0) ? 6'd1 : cfg.read_sample_ticks;
   assign rd_end_lim    = {3'd0, sample_eff} + {1'b0, cfg.read_recover_ticks};
   assign rd_sample_hit = (tick_ff == {14'd0, sample_eff});
   assign rd_end        = (tick_ff >= {11'd0, rd_end_lim});
   assign rd_shift      = rd_sample_hit ? {line_level, shift_ff[7:1]} : shift_ff;

   // Next state of the sequencer.
   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      step_in   = step_ff;
      shift_in  = shift_ff;
      result_in = result_ff;
      flag_in   = flag_ff;
      if (step_en) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (start_req) begin
                  phase_in = PH_RST_LOW;
                  tick_in  = '0;
                  step_in  = 3'd0;
                  bit_in   = 3'd0;
                  flag_in  = 1'b0;
               end
            end
            PH_RST_LOW: begin
               tick_in = tick_plus[TICK_W-1:0];
               if (tick_plus >= {9'd0, cfg.reset_low_ticks}) begin
                  phase_in = PH_PRESENCE;
                  tick_in  = '0;
               end
            end
            PH_PRESENCE: begin
               if (!line_level) begin
                  phase_in = PH_RECOVER;
                  tick_in  = '0;
               end else begin
                  tick_in = tick_plus[TICK_W-1:0];
                  if (tick_plus > {5'd0, cfg.presence_timeout_ticks}) begin
                     flag_in  = 1'b1;
                     phase_in = PH_RECOVER;
                     tick_in  = '0;
                  end
               end
            end
            PH_RECOVER: begin
               tick_in = tick_plus[TICK_W-1:0];
               if (tick_plus >= {5'd0, cfg.recovery_ticks}) begin
                  phase_in = PH_WRITE;
                  tick_in  = '0;
                  bit_in   = 3'd0;
                  shift_in = command_for(step_ff);
               end
            end
            PH_WRITE: begin
               if (tick_ff == '0) begin
                  tick_in = tick_plus[TICK_W-1:0];
               end else if (tick_ff <= {12'd0, cfg.write_slot_ticks}) begin
                  tick_in = tick_plus[TICK_W-1:0];
               end else begin
                  // End of the release tick: move to the next bit or byte.
                  shift_in = {1'b0, shift_ff[7:1]};
                  tick_in  = '0;
                  bit_in   = bit_ff + 3'd1;
                  if (bit_ff == 3'd7) begin
                     step_in = step_plus;
                     if (step_plus == STEP_WAIT) begin
                        phase_in = PH_CONVERT;
                     end else if (step_plus >= STEP_RD_LOW) begin
                        step_in  = STEP_RD_LOW;
                        phase_in = PH_READ;
                        shift_in = 8'd0;
                     end else begin
                        shift_in = command_for(step_plus);
                     end
                  end
               end
            end
            PH_CONVERT: begin
               tick_in = tick_plus[TICK_W-1:0];
               if (tick_plus >= {1'b0, cfg.convert_wait_ticks}) begin
                  phase_in = PH_RST_LOW;
                  tick_in  = '0;
               end
            end
            PH_READ: begin
               if (tick_ff == '0) begin
                  tick_in = tick_plus[TICK_W-1:0];
               end else begin
                  shift_in = rd_shift;
                  if (rd_end) begin
                     tick_in = '0;
                     bit_in  = bit_ff + 3'd1;
                     if (bit_ff == 3'd7) begin
                        if (step_ff == STEP_RD_LOW) begin
                           result_in = {result_ff[15:8], rd_shift};
                           step_in   = STEP_RD_HIGH;
                           shift_in  = 8'd0;
                        end else begin
                           result_in = {rd_shift, result_ff[7:0]};
                           step_in   = 3'd0;
                           phase_in  = PH_IDLE;
                        end
                     end
                  end else begin
                     tick_in = tick_plus[TICK_W-1:0];
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
               tick_in  = '0;
            end
         endcase
      end
   end

   // Bus drive and completion for the current tick.
   always_comb begin
      drive = 1'b0;
      done  = 1'b0;
      unique case (phase_ff)
         PH_RST_LOW: drive = 1'b1;
         PH_WRITE: begin
            if (tick_ff == '0) begin
               drive = 1'b1;
            end else if (tick_ff <= {12'd0, cfg.write_slot_ticks}) begin
               drive = !shift_ff[0];
            end
         end
         PH_READ: begin
            if (tick_ff == '0) begin
               drive = 1'b1;
            end else if (rd_end && bit_ff == 3'd7 && step_ff != STEP_RD_LOW) begin
               done = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         tick_ff   <= '0;
         bit_ff    <= 3'd0;
         step_ff   <= 3'd0;
         shift_ff  <= 8'd0;
         result_ff <= 16'd0;
         flag_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         step_ff   <= step_in;
         shift_ff  <= shift_in;
         result_ff <= result_in;
         flag_ff   <= flag_in;
      end
   end

   assign res.drive_low        = drive;
   assign res.busy_res         = (phase_in != PH_IDLE);
   assign res.done_res         = done;
   assign res.presence_missing = flag_in;
   assign res.temperature_raw  = result_in;

   // The bus is pulled low only in the reset pulse and in bit slots.
   a_drive_phase: assert property (@(posedge clock) disable iff (reset)
      step_en && drive |-> phase_ff == PH_RST_LOW || phase_ff == PH_WRITE
                           || phase_ff == PH_READ)
      else $error("bus driven outside a slot or reset pulse");

   // The bit counter is at rest outside of bit slots.
   a_bit_rest: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_WRITE && phase_ff != PH_READ |-> bit_ff == 3'd0)
      else $error("bit counter not at zero outside slots");

   // A completed read returns the sequencer to idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && done |=> phase_ff == PH_IDLE && step_ff == 3'd0)
      else $error("sequencer not idle after completion");

   // Byte step never goes past the high read byte.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_RD_HIGH)
      else $error("byte step out of range");

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Testbench for the one-wire temperature read master: bus ticks in, one response per tick.
// Depends on owtrm_pkg, the owtrm channel interfaces and onewire_temperature_read_master.
module tb;
   import owtrm_pkg::*;

   // Index past the last timing register; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int STALL_LIMIT = 2000;

   typedef logic [CSR_DATA_W-1:0] timing_set_type [7];

   // Tracks the read sequence tick by tick and holds the responses it predicts.
   class onewire_read_checker;
      cfg_type         cfg;
      phase_type       phase;
      logic [TICK_W-1:0] tick_cnt;
      logic [2:0]      bit_idx;
      logic [2:0]      step;
      logic [7:0]      shreg;
      logic [15:0]     word;
      logic            no_presence;
      rsp_payload_type tick_rsp_q[$];
      int              errors;

      function new();
         cfg.reset_low_ticks        = 12'd642;
         cfg.presence_timeout_ticks = 16'd5000;
         cfg.recovery_ticks         = 16'd1000;
         cfg.write_slot_ticks       = 8'd68;
         cfg.read_sample_ticks      = 6'd6;
         cfg.read_recover_ticks     = 8'd48;
         cfg.convert_wait_ticks     = 20'd100000;
         phase       = PH_IDLE;
         tick_cnt    = '0;
         bit_idx     = '0;
         step        = '0;
         shreg       = '0;
         word        = '0;
         no_presence = 1'b0;
         errors      = 0;
      endfunction

      // Register writes are truncated to the width of the register.
      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_RESET_LOW:  cfg.reset_low_ticks        = data[11:0];
            REG_PRES_TMO:   cfg.presence_timeout_ticks = data[15:0];
            REG_RECOVERY:   cfg.recovery_ticks         = data[15:0];
            REG_WRITE_SLOT: cfg.write_slot_ticks       = data[7:0];
            REG_RD_SAMPLE:  cfg.read_sample_ticks      = data[5:0];
            REG_RD_RECOVER: cfg.read_recover_ticks     = data[7:0];
            REG_CONV_WAIT:  cfg.convert_wait_ticks     = data[19:0];
            default: ;
         endcase
      endfunction

      // Loads the command byte for the current step and opens its first slot.
      function void start_write();
         phase    = PH_WRITE;
         tick_cnt = '0;
         bit_idx  = '0;
         case (step)
            STEP_CONVERT:  shreg = CMD_CONVERT;
            STEP_READ_SCR: shreg = CMD_READ_SCR;
            default:       shreg = CMD_SKIP_ROM;
         endcase
      endfunction

      // Advances the sequencer by one accepted tick and queues the response it gives.
      function void note_tick(logic start, logic line);
         rsp_payload_type exp;
         logic            drive;
         logic            done;
         int unsigned     sample_at;
         drive = 1'b0;
         done  = 1'b0;
         sample_at = (cfg.read_sample_ticks == 0) ? 1 : cfg.read_sample_ticks;
         case (phase)
            PH_IDLE: begin
               if (start) begin
                  phase       = PH_RST_LOW;
                  tick_cnt    = '0;
                  step        = '0;
                  bit_idx     = '0;
                  no_presence = 1'b0;
               end
            end
            PH_RST_LOW: begin
               drive    = 1'b1;
               tick_cnt = tick_cnt + 1'b1;
               if (tick_cnt >= cfg.reset_low_ticks) begin
                  phase    = PH_PRESENCE;
                  tick_cnt = '0;
               end
            end
            PH_PRESENCE: begin
               // A low line is the presence pulse; too many high samples flag its absence.
               if (!line) begin
                  phase    = PH_RECOVER;
                  tick_cnt = '0;
               end else begin
                  tick_cnt = tick_cnt + 1'b1;
                  if (tick_cnt > cfg.presence_timeout_ticks) begin
                     no_presence = 1'b1;
                     phase       = PH_RECOVER;
                     tick_cnt    = '0;
                  end
               end
            end
            PH_RECOVER: begin
               tick_cnt = tick_cnt + 1'b1;
               if (tick_cnt >= cfg.recovery_ticks) start_write();
            end
            PH_WRITE: begin
               if (tick_cnt == 0) begin
                  drive    = 1'b1;
                  tick_cnt = tick_cnt + 1'b1;
               end else if (tick_cnt <= cfg.write_slot_ticks) begin
                  drive    = ~shreg[0];
                  tick_cnt = tick_cnt + 1'b1;
               end else begin
                  shreg    = shreg >> 1;
                  tick_cnt = '0;
                  if (bit_idx == 3'd7) begin
                     bit_idx = '0;
                     step    = step + 3'd1;
                     if (step == STEP_WAIT) begin
                        phase = PH_CONVERT;
                     end else if (step >= STEP_RD_LOW) begin
                        step     = STEP_RD_LOW;
                        phase    = PH_READ;
                        tick_cnt = '0;
                        shreg    = '0;
                     end else begin
                        start_write();
                     end
                  end else begin
                     bit_idx = bit_idx + 3'd1;
                  end
               end
            end
            PH_CONVERT: begin
               tick_cnt = tick_cnt + 1'b1;
               if (tick_cnt >= cfg.convert_wait_ticks) begin
                  phase    = PH_RST_LOW;
                  tick_cnt = '0;
               end
            end
            PH_READ: begin
               if (tick_cnt == 0) begin
                  drive    = 1'b1;
                  tick_cnt = tick_cnt + 1'b1;
               end else begin
                  if (tick_cnt == sample_at) shreg = {line, shreg[7:1]};
                  if (tick_cnt >= sample_at + cfg.read_recover_ticks) begin
                     tick_cnt = '0;
                     if (bit_idx == 3'd7) begin
                        bit_idx = '0;
                        if (step == STEP_RD_LOW) begin
                           word[7:0] = shreg;
                           step      = STEP_RD_HIGH;
                           shreg     = '0;
                        end else begin
                           word[15:8] = shreg;
                           step       = '0;
                           phase      = PH_IDLE;
                           done       = 1'b1;
                        end
                     end else begin
                        bit_idx = bit_idx + 3'd1;
                     end
                  end else begin
                     tick_cnt = tick_cnt + 1'b1;
                  end
               end
            end
            default: begin
               phase    = PH_IDLE;
               tick_cnt = '0;
            end
         endcase
         exp.drive_low        = drive;
         exp.busy_res         = (phase != PH_IDLE);
         exp.done_res         = done;
         exp.presence_missing = no_presence;
         exp.temperature_raw  = word;
         tick_rsp_q.push_back(exp);
      endfunction

      function void compare_field(string name, logic [15:0] exp, logic [15:0] got);
         if (got !== exp) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, exp, got);
            errors++;
         end
      endfunction

      // Compares one response with the oldest prediction.
      function void check_response(rsp_payload_type got);
         rsp_payload_type exp;
         if (tick_rsp_q.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         exp = tick_rsp_q.pop_front();
         compare_field("drive_low", 16'(exp.drive_low), 16'(got.drive_low));
         compare_field("busy_res", 16'(exp.busy_res), 16'(got.busy_res));
         compare_field("done_res", 16'(exp.done_res), 16'(got.done_res));
         compare_field("presence_missing", 16'(exp.presence_missing),
                       16'(got.presence_missing));
         compare_field("temperature_raw", exp.temperature_raw, got.temperature_raw);
      endfunction

      function int pending();
         return tick_rsp_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic steady = 1'b0;
   logic absent_sensor = 1'b0;
   int   stall_cycles = 0;
   onewire_read_checker sb = new();

   owtrm_req_if req_bus();
   owtrm_rsp_if rsp_bus();
   owtrm_csr_if csr_bus();

   onewire_temperature_read_master dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // All inputs start at known values.
   initial begin
      req_bus.valid      = 1'b0;
      req_bus.start_req  = 1'b0;
      req_bus.line_level = 1'b0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;
   end

   // The response side stalls at random, except during the steady stretch.
   always @(negedge clock) begin
      rsp_bus.ready = steady || ($urandom_range(99) >= 14);
   end

   // Accepted requests feed the predictor; accepted responses are checked against it.
   always @(posedge clock) begin
      rsp_payload_type got;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) sb.write_reg(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready) sb.note_tick(req_bus.start_req, req_bus.line_level);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.drive_low        = rsp_bus.drive_low;
            got.busy_res         = rsp_bus.busy_res;
            got.done_res         = rsp_bus.done_res;
            got.presence_missing = rsp_bus.presence_missing;
            got.temperature_raw  = rsp_bus.temperature_raw;
            sb.check_response(got);
         end
      end
   end

   // Counts cycles in which no channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // Presents one bus tick, with random idle cycles ahead of it. Entered and left at a falling edge.
   task automatic send_tick(input logic start, input logic line);
      while (!steady && $urandom_range(99) < 14) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.start_req  = start;
      req_bus.line_level = line;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = data;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Stops requests and waits for every predicted response to arrive.
   task automatic drain();
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Plays the sensor side: answers presence unless it is absent, returns random read bits,
   // and now and then sends a start that the busy sequencer must ignore.
   task automatic pick_tick(output logic start, output logic line);
      start = ($urandom_range(99) < 4);
      case (sb.phase)
         PH_IDLE: begin
            start = ($urandom_range(99) < 40);
            line  = 1'($urandom_range(1));
            if (start) absent_sensor = ($urandom_range(99) < 15);
         end
         PH_RST_LOW:  line = ($urandom_range(9) == 0) ? 1'($urandom_range(1)) : 1'b0;
         PH_PRESENCE: line = absent_sensor || ($urandom_range(3) != 0);
         PH_READ:     line = 1'($urandom_range(1));
         default:     line = ($urandom_range(9) != 0);
      endcase
   endtask

   // Writes a full set of timing registers, then runs random ticks under it.
   task automatic run_timing(input timing_set_type vals, input int n_ticks);
      logic start;
      logic line;
      drain();
      write_csr(REG_RESET_LOW, vals[0]);
      write_csr(REG_PRES_TMO, vals[1]);
      write_csr(REG_RECOVERY, vals[2]);
      write_csr(REG_WRITE_SLOT, vals[3]);
      write_csr(REG_RD_SAMPLE, vals[4]);
      write_csr(REG_RD_RECOVER, vals[5]);
      write_csr(REG_CONV_WAIT, vals[6]);
      if ($urandom_range(1)) write_csr(REG_UNUSED, CSR_DATA_W'($urandom));
      repeat (n_ticks) begin
         pick_tick(start, line);
         send_tick(start, line);
      end
   endtask

   initial begin
      timing_set_type vals;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed start under the reset timing: idle ticks, a start, and a start while busy.
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);

      // All-zero timing, applied in mid-reset: zero lengths act as one tick and a
      // presence timeout of zero flags the first high sample.
      vals = '{default: '0};
      drain();
      write_csr(REG_UNUSED, '1);
      run_timing(vals, 0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      run_timing(vals, 120);

      // All ones in every data bit: each register takes its largest value.
      vals = '{default: '1};
      run_timing(vals, 30);

      // Short timing, many complete reads.
      vals = '{20'd2, 20'd6, 20'd1, 20'd1, 20'd1, 20'd1, 20'd3};
      run_timing(vals, 200);

      // Same kind of timing with no idling on either side.
      steady = 1'b1;
      vals = '{20'd1, 20'd3, 20'd2, 20'd2, 20'd2, 20'd2, 20'd2};
      run_timing(vals, 250);
      steady = 1'b0;

      // Longest write slots, then longest read slots, each taking over mid-sequence.
      vals = '{20'd1, 20'd8, 20'd1, 20'd255, 20'd1, 20'd1, 20'd1};
      run_timing(vals, 60);
      vals = '{20'd1, 20'd8, 20'd1, 20'd1, 20'd63, 20'd255, 20'd1};
      run_timing(vals, 60);

      // Random short timing sets.
      repeat (8) begin
         vals[0] = CSR_DATA_W'($urandom_range(6));
         vals[1] = CSR_DATA_W'($urandom_range(12));
         vals[2] = CSR_DATA_W'($urandom_range(5));
         vals[3] = CSR_DATA_W'($urandom_range(5));
         vals[4] = CSR_DATA_W'($urandom_range(5));
         vals[5] = CSR_DATA_W'($urandom_range(5));
         vals[6] = CSR_DATA_W'($urandom_range(8));
         run_timing(vals, 20);
      end

      drain();
      repeat (8) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

>>> sim.f
hw/rtl/owtrm_pkg.sv
hw/rtl/owtrm_if.sv
hw/rtl/owtrm_csr.sv
hw/rtl/owtrm_seq.sv
hw/rtl/onewire_temperature_read_master.sv
verif/tb.sv
